### rtl/core/b7s_pkg.sv
// Shared types, constants and the segment table for the seven-segment converter.
package b7s_pkg;

    localparam int VALUE_WIDTH     = 16;
    localparam int BCD_DIGITS      = 5;
    localparam int BCD_WIDTH       = 4 * BCD_DIGITS;
    localparam int SEG_WIDTH       = 8;
    localparam int STEPS_PER_STAGE = 4;
    localparam int NUM_STAGES      = VALUE_WIDTH / STEPS_PER_STAGE;

    localparam logic [SEG_WIDTH-1:0] SEG_BLANK = 8'hFF;

    // Conversion word: BCD digits on top, remaining binary bits below.
    typedef struct packed {
        logic [BCD_WIDTH-1:0]   bcd;
        logic [VALUE_WIDTH-1:0] bin;
    } dabble_t;

    // Active-low, bit 7 = A ... bit 1 = G, bit 0 = DP.
    function automatic logic [SEG_WIDTH-1:0] seg_code(input logic [3:0] digit);
        logic [SEG_WIDTH-1:0] code;
        unique case (digit)
            4'd0:    code = 8'h03;
            4'd1:    code = 8'h9F;
            4'd2:    code = 8'h25;
            4'd3:    code = 8'h0D;
            4'd4:    code = 8'h99;
            4'd5:    code = 8'h49;
            4'd6:    code = 8'h41;
            4'd7:    code = 8'h1F;
            4'd8:    code = 8'h01;
            4'd9:    code = 8'h09;
            default: code = SEG_BLANK;
        endcase
        return code;
    endfunction

endpackage

### rtl/core/binary_to_seven_segment_digits_core.sv
// Top level: 16-bit binary value to four blanked seven-segment digit codes.
// Accepts one value per cycle unless the result side stalls, and returns one beat of five
// active-low segment codes (thousands, hundreds, colon, tens, ones) per value:
// four stages each run four shift-and-add-3 steps of the binary to BCD conversion,
// then an output register applies the segment table and leading-zero blanking.
// Only the low four decimal digits are shown; the colon code is always all off.
// A stall on the result side holds an occupied stage only when no stage ahead is empty;
// empty stages still fill, so a value is taken whenever some stage ahead can move.
module binary_to_seven_segment_digits_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        value_valid,
    output logic        value_ready,
    input  logic [15:0] value,
    output logic        segments_valid,
    input  logic        segments_ready,
    output logic [7:0]  thousands_segments,
    output logic [7:0]  hundreds_segments,
    output logic [7:0]  colon_segments,
    output logic [7:0]  tens_segments,
    output logic [7:0]  ones_segments
);
    import b7s_pkg::*;

    logic    stage_valid   [NUM_STAGES];
    dabble_t stage_data    [NUM_STAGES];
    logic    stage_advance [NUM_STAGES];
    logic    out_advance;

    logic                 segments_valid_reg;
    logic [SEG_WIDTH-1:0] thousands_reg, hundreds_reg, tens_reg, ones_reg;
    logic [SEG_WIDTH-1:0] thousands_next, hundreds_next, tens_next, ones_next;

    assign out_advance = !segments_valid_reg || segments_ready;

    // ready chain runs from the output side back toward the input
    always_comb
    begin
        stage_advance[NUM_STAGES-1] = !stage_valid[NUM_STAGES-1] || out_advance;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            stage_advance[i] = !stage_valid[i] || stage_advance[i+1];
        end
    end

    assign value_ready = stage_advance[0];

    for (genvar i = 0; i < NUM_STAGES; i++)
    begin : g_stage
        if (i == 0)
        begin : g_first
            b7s_dabble_stage u_stage (
                .clk            (clk),
                .rst_n          (rst_n),
                .advance        (stage_advance[i]),
                .upstream_valid (value_valid),
                .upstream_data  ({{BCD_WIDTH{1'b0}}, value}),
                .valid          (stage_valid[i]),
                .data           (stage_data[i])
            );
        end
        else
        begin : g_rest
            b7s_dabble_stage u_stage (
                .clk            (clk),
                .rst_n          (rst_n),
                .advance        (stage_advance[i]),
                .upstream_valid (stage_valid[i-1]),
                .upstream_data  (stage_data[i-1]),
                .valid          (stage_valid[i]),
                .data           (stage_data[i])
            );
        end
    end

    // Ten-thousands digit (bcd[19:16]) is dropped.
    always_comb
    begin
        logic [3:0] th, hu, te, on;
        th = stage_data[NUM_STAGES-1].bcd[15:12];
        hu = stage_data[NUM_STAGES-1].bcd[11:8];
        te = stage_data[NUM_STAGES-1].bcd[7:4];
        on = stage_data[NUM_STAGES-1].bcd[3:0];
        thousands_next = (th == 4'd0) ? SEG_BLANK : seg_code(th);
        hundreds_next  = (th == 4'd0 && hu == 4'd0) ? SEG_BLANK : seg_code(hu);
        tens_next      = (th == 4'd0 && hu == 4'd0 && te == 4'd0) ? SEG_BLANK : seg_code(te);
        ones_next      = seg_code(on);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            segments_valid_reg <= 1'b0;
        end
        else if (out_advance)
        begin
            segments_valid_reg <= stage_valid[NUM_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_advance && stage_valid[NUM_STAGES-1])
        begin
            thousands_reg <= thousands_next;
            hundreds_reg  <= hundreds_next;
            tens_reg      <= tens_next;
            ones_reg      <= ones_next;
        end
    end

    assign segments_valid     = segments_valid_reg;
    assign thousands_segments = thousands_reg;
    assign hundreds_segments  = hundreds_reg;
    assign colon_segments     = SEG_BLANK;
    assign tens_segments      = tens_reg;
    assign ones_segments      = ones_reg;

endmodule

### rtl/core/b7s_dabble_stage.sv
// One registered pipeline stage of the shift-and-add-3 binary to BCD conversion.
module b7s_dabble_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            advance,
    input  logic            upstream_valid,
    input  b7s_pkg::dabble_t upstream_data,
    output logic            valid,
    output b7s_pkg::dabble_t data
);
    import b7s_pkg::*;

    logic    valid_reg;
    dabble_t data_reg;
    dabble_t data_next;

    always_comb
    begin
        logic [BCD_WIDTH+VALUE_WIDTH-1:0] word;
        word = upstream_data;
        for (int s = 0; s < STEPS_PER_STAGE; s++)
        begin
            // digits of 5 or more get +3 so the shift carries into the next digit
            for (int d = 0; d < BCD_DIGITS; d++)
            begin
                if (word[VALUE_WIDTH + 4*d +: 4] >= 4'd5)
                begin
                    word[VALUE_WIDTH + 4*d +: 4] = word[VALUE_WIDTH + 4*d +: 4] + 4'd3;
                end
            end
            word = {word[BCD_WIDTH+VALUE_WIDTH-2:0], 1'b0};
        end
        data_next = word;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= upstream_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && upstream_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign valid = valid_reg;
    assign data  = data_reg;

endmodule
